// ===== rtl/ssr_pkg.sv =====
// ============================================================================
// ssr_pkg: shared types and constants for the stream substring replacer
// Payload structs, register indexes, controller command and status groups.
// ============================================================================
`default_nettype none

package ssr_pkg;

    // Default sizes of the search and substitute strings
    localparam int unsigned SSR_MAX_SEARCH_DEF = 8;
    localparam int unsigned SSR_MAX_SUB_DEF    = 8;

    // Configuration port geometry
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_LEN_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_BYTES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_LEN      = 2'd3;

    // Input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       end_of_text;
    } t_ssr_in;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_byte_present;
        logic       out_end_of_text;
        logic       last_of_run;
    } t_ssr_out;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the accepted item, restart the candidate scan
        logic step;    // advance to the next candidate start
        logic settle;  // record scan outcome and the emit plan
        logic emit;    // write one result into the output register
        logic commit;  // update the partial match length
    } t_ssr_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_live;    // presented item carries a byte or an end mark
        logic cand_ok;    // current candidate suffix is a search prefix
        logic emit_last;  // current result ends the run
        logic emit_skip;  // run produces no result at all
        logic out_free;   // output register can take a result this cycle
    } t_ssr_sts;

    // Byte i of a configuration word, zero beyond the word
    function automatic logic [7:0] cfg_byte(logic [CFG_DATA_W-1:0] word, int unsigned i);
        logic [CFG_DATA_W-1:0] shifted;
        shifted = word >> (8 * i);
        return shifted[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssr_ctrl.sv =====
// ============================================================================
// ssr_ctrl: sequencing for the stream substring replacer
// Accepts an item, steps the candidate scan, then drives the result run.
// ============================================================================
`default_nettype none

module ssr_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  ssr_pkg::t_ssr_sts i_sts,
    output ssr_pkg::t_ssr_cmd o_cmd
);
    import ssr_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                // Empty items transfer here and change nothing
                if (i_in_valid && i_sts.in_live) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.cand_ok) begin
                    o_cmd.settle = 1'b1;
                    n_state      = ST_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_sts.emit_skip) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A run always finishes back in idle
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == ST_IDLE))
        else $error("ssr_ctrl: commit did not return to idle");

    // An accepted item always starts a scan
    a_load_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_SEARCH))
        else $error("ssr_ctrl: load did not enter search");

    // Load, step, settle and emit never overlap; commit may come with emit
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.step, o_cmd.settle, o_cmd.emit}))
        else $error("ssr_ctrl: overlapping datapath commands");

endmodule

`default_nettype wire

// ===== rtl/ssr_dpath.sv =====
// ============================================================================
// ssr_dpath: datapath for the stream substring replacer
// Configuration registers, partial match length, candidate check, result
// selection and the output register.
// ============================================================================
`default_nettype none

module ssr_dpath #(
    parameter int unsigned MAX_SEARCH_BYTES     = ssr_pkg::SSR_MAX_SEARCH_DEF,
    parameter int unsigned MAX_SUBSTITUTE_BYTES = ssr_pkg::SSR_MAX_SUB_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  ssr_pkg::t_ssr_in                    i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output ssr_pkg::t_ssr_out                   o_out_data,
    input  wire                                 i_cfg_wr_en,
    input  wire [ssr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [ssr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  ssr_pkg::t_ssr_cmd                   i_cmd,
    output ssr_pkg::t_ssr_sts                   o_sts
);
    import ssr_pkg::*;

    localparam int unsigned KW    = $clog2(MAX_SEARCH_BYTES + 1);
    localparam int unsigned SW    = $clog2(MAX_SUBSTITUTE_BYTES + 1);
    localparam int unsigned MAXB  = (MAX_SEARCH_BYTES > MAX_SUBSTITUTE_BYTES) ?
                                    MAX_SEARCH_BYTES : MAX_SUBSTITUTE_BYTES;
    localparam int unsigned CW    = $clog2(MAXB + 1);
    localparam int unsigned BUFW  = (MAX_SEARCH_BYTES + 1) * 8;
    localparam int unsigned SUBW  = MAX_SUBSTITUTE_BYTES * 8;

    // Configuration
    logic [CFG_DATA_W-1:0] r_search_bytes;
    logic [CFG_LEN_W-1:0]  r_search_len;
    logic [CFG_DATA_W-1:0] r_sub_bytes;
    logic [CFG_LEN_W-1:0]  r_sub_len;

    // Item and scan state
    logic [KW-1:0] r_k;
    logic [7:0]    r_c;
    logic          r_present;
    logic          r_end;
    logic [KW-1:0] r_len;
    logic [KW-1:0] r_s;
    logic          r_match;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [KW-1:0] r_newk;

    // Output register
    logic     r_out_valid;
    t_ssr_out r_out;

    logic [KW-1:0]   slen_eff;
    logic [SW-1:0]   sub_eff;
    logic [KW-1:0]   k_eff;
    logic [KW-1:0]   m;
    logic [BUFW-1:0] hold_buf;
    logic [BUFW-1:0] cand_buf;
    logic [BUFW-1:0] emit_buf;
    logic [SUBW-1:0] sub_buf;
    logic [SUBW-1:0] sub_shift;
    logic [BUFW-1:0] srch_buf;
    logic            cand_ok;
    logic            match_now;
    logic            emit_last;
    logic            bare;
    logic [7:0]      emit_byte;
    logic            out_free;

    // Saturate configured lengths
    always_comb begin
        if (r_search_len > MAX_SEARCH_BYTES) begin
            slen_eff = KW'(MAX_SEARCH_BYTES);
        end else begin
            slen_eff = KW'(r_search_len);
        end
        if (r_sub_len > MAX_SUBSTITUTE_BYTES) begin
            sub_eff = SW'(MAX_SUBSTITUTE_BYTES);
        end else begin
            sub_eff = SW'(r_sub_len);
        end
        k_eff = (r_k >= slen_eff) ? '0 : r_k;
    end

    // Held bytes are a search prefix; the new byte follows them
    always_comb begin
        hold_buf = '0;
        srch_buf = '0;
        for (int i = 0; i <= MAX_SEARCH_BYTES; i++) begin
            if (i < MAX_SEARCH_BYTES) begin
                srch_buf[8*i +: 8] = cfg_byte(r_search_bytes, i);
            end
            if (KW'(i) < r_k) begin
                hold_buf[8*i +: 8] = cfg_byte(r_search_bytes, i);
            end else if ((KW'(i) == r_k) && r_present) begin
                hold_buf[8*i +: 8] = r_c;
            end
        end
        for (int j = 0; j < MAX_SUBSTITUTE_BYTES; j++) begin
            sub_buf[8*j +: 8] = cfg_byte(r_sub_bytes, j);
        end
    end

    // Check the candidate suffix starting at r_s against the search prefix
    always_comb begin
        m        = r_len - r_s;
        cand_buf = hold_buf >> {r_s, 3'b000};
        cand_ok  = (m <= slen_eff);
        for (int j = 0; j < MAX_SEARCH_BYTES; j++) begin
            if ((KW'(j) < m) && (cand_buf[8*j +: 8] != srch_buf[8*j +: 8])) begin
                cand_ok = 1'b0;
            end
        end
        match_now = (m == slen_eff) && (slen_eff != '0);
    end

    // Select the current result
    always_comb begin
        emit_buf  = hold_buf >> {r_idx, 3'b000};
        sub_shift = sub_buf >> {r_idx, 3'b000};
        emit_byte = r_match ? sub_shift[7:0] : emit_buf[7:0];
        bare      = (r_cnt == '0);
        emit_last = bare || (r_idx == (r_cnt - CW'(1)));
        out_free  = !r_out_valid || !i_out_stall;
    end

    // Configuration registers and partial match length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_bytes <= '0;
            r_search_len   <= CFG_LEN_W'(1);
            r_sub_bytes    <= '0;
            r_sub_len      <= '0;
            r_k            <= '0;
        end else begin
            if (i_cmd.load) begin
                r_k <= k_eff;
            end else if (i_cmd.commit) begin
                r_k <= r_newk;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SEARCH_BYTES: begin
                        r_search_bytes <= i_cfg_data;
                        r_k            <= '0;
                    end
                    CFG_SEARCH_LEN: begin
                        r_search_len <= i_cfg_data[CFG_LEN_W-1:0];
                        r_k          <= '0;
                    end
                    CFG_SUB_BYTES: begin
                        r_sub_bytes <= i_cfg_data;
                    end
                    CFG_SUB_LEN: begin
                        r_sub_len <= i_cfg_data[CFG_LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item capture, scan and run bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c       <= i_in_data.text_byte;
            r_present <= i_in_data.byte_present;
            r_end     <= i_in_data.end_of_text;
            r_len     <= k_eff + KW'(i_in_data.byte_present);
            r_s       <= '0;
        end
        if (i_cmd.step) begin
            r_s <= r_s + KW'(1);
        end
        if (i_cmd.settle) begin
            r_match <= match_now;
            r_idx   <= '0;
            if (match_now) begin
                r_cnt <= CW'(sub_eff);
            end else begin
                r_cnt <= CW'(r_s) + (r_end ? CW'(m) : '0);
            end
            r_newk <= (match_now || r_end) ? '0 : m;
        end
        if (i_cmd.emit) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte         <= bare ? 8'h00 : emit_byte;
            r_out.out_byte_present <= !bare;
            r_out.out_end_of_text  <= r_end && emit_last;
            r_out.last_of_run      <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.in_live   = i_in_data.byte_present || i_in_data.end_of_text;
    assign o_sts.cand_ok   = cand_ok;
    assign o_sts.emit_last = emit_last;
    assign o_sts.emit_skip = bare && !r_end;
    assign o_sts.out_free  = out_free;

    // Held bytes always stay shorter than the search string
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k == '0) || (r_k < slen_eff))
        else $error("ssr_dpath: partial match length out of range");

    // The empty suffix always matches, so the scan never runs past the item
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_s < r_len))
        else $error("ssr_dpath: candidate scan overran the held bytes");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.emit)
        else $error("ssr_dpath: output register overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/stream_substring_replace_top.sv =====
// ============================================================================
// stream_substring_replace_top: streaming search and replace
// Rewrites a byte stream with every leftmost non-overlapping occurrence of
// the search string replaced by the substitute string.
// ============================================================================
// Sequence: an item with a byte or an end mark transfers in idle; the held
//   bytes are then scanned for the new match start s (one candidate per
//   cycle), then the results go one at a time to the single output
//   register, waiting while it stalls. No new item is taken until the run
//   is done; empty items transfer in idle and produce no result.
// Reset: synchronous, active low; clears the partial match and configuration, but sets the search length to one.
`default_nettype none

module stream_substring_replace_top #(
    parameter int unsigned MAX_SEARCH_BYTES     = ssr_pkg::SSR_MAX_SEARCH_DEF,
    parameter int unsigned MAX_SUBSTITUTE_BYTES = ssr_pkg::SSR_MAX_SUB_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  ssr_pkg::t_ssr_in              i_in_data,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output ssr_pkg::t_ssr_out             o_out_data,
    input  wire                           i_cfg_wr_en,
    input  wire [ssr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [ssr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssr_pkg::*;

    t_ssr_cmd cmd;
    t_ssr_sts sts;

    // Sequencer
    ssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    ssr_dpath #(
        .MAX_SEARCH_BYTES     (MAX_SEARCH_BYTES),
        .MAX_SUBSTITUTE_BYTES (MAX_SUBSTITUTE_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire
